[rtl/nsrc_pkg.sv]
// nsrc_pkg: shared types and constants for the nearest sample rate converter
// no dependencies; imported by every module of the block
package nsrc_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int STEP_W        = 13;
  localparam int WIDTH_W       = 2;
  localparam int PEAK_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_OUT       = 16;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(256);
  localparam logic [WIDTH_W-1:0] WIDTH_16BIT = WIDTH_W'(2);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_16BIT;
  localparam logic [PEAK_W-1:0]  PEAK_MAX    = PEAK_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE    = CFG_IDX_W'(0),
    REG_SAMPLE_WIDTH = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
  } dp_status_t;

endpackage

[rtl/nearest_sample_rate_converter.sv]
// nearest_sample_rate_converter: top level, nearest-sample resampler with running peak
// depends on nsrc_pkg, nsrc_ctrl and nsrc_datapath
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_stall   | in_raw_sample[15:0], in_end_of_sound
//  out     | out_valid / out_stall | out_sample[15:0], out_peak_level[7:0],
//          |                       | out_run_last, out_sound_end
//  cfg     | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[12:0]
//
// an input transaction has an accept step in ST_IDLE and then one emit step per output sample it produces
// (up to 16 outputs); a skipped input has only the accept step
// the emit sequencer produces one output per cycle while the output is not stalled, through a single result register
// reset clears phase, peak, state and the output valid flag and loads step 256 and 16-bit mode
// a stalled output holds the sequencer; the next input is taken while the last result waits
module nearest_sample_rate_converter
  import nsrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STEP_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_W-1:0]        in_raw_sample,
  input  logic                       in_end_of_sound,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic [PEAK_W-1:0]          out_peak_level,
  output logic                       out_run_last,
  output logic                       out_sound_end
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  nsrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  nsrc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_raw_sample   (in_raw_sample),
    .in_end_of_sound (in_end_of_sound),
    .cmd             (cmd),
    .sts             (sts),
    .out_sample      (out_sample),
    .out_peak_level  (out_peak_level),
    .out_run_last    (out_run_last),
    .out_sound_end   (out_sound_end)
  );

endmodule

[rtl/nsrc_datapath.sv]
// nsrc_datapath: config registers, phase accumulator, peak tracker, result register
// depends on nsrc_pkg; driven by nsrc_ctrl through ctrl_cmd_t
module nsrc_datapath
  import nsrc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STEP_W-1:0]          cfg_data,
  input  logic [SAMPLE_W-1:0]        in_raw_sample,
  input  logic                       in_end_of_sound,
  input  ctrl_cmd_t                  cmd,
  output dp_status_t                 sts,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic [PEAK_W-1:0]          out_peak_level,
  output logic                       out_run_last,
  output logic                       out_sound_end
);

  localparam int PHASE_W  = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int MIN_STEP = ((1 << FRAC_BITS) + MAX_OUT - 1) / MAX_OUT;
  localparam logic [PHASE_W-1:0] ONE_POS = PHASE_W'(1) << FRAC_BITS;

  logic [STEP_W-1:0]   step_size_r;
  logic [WIDTH_W-1:0]  sample_width_r;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [PEAK_W-1:0]   peak_r, peak_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic [PEAK_W-1:0]   mag_r;
  logic                eos_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic [PEAK_W-1:0]   out_peak_r;
  logic                out_run_last_r;
  logic                out_sound_end_r;

  logic [SAMPLE_W-1:0] wide_sample;
  logic [SAMPLE_W-1:0] abs_sample;
  logic [STEP_W-1:0]   step_eff;
  logic [PHASE_W-1:0]  phase_sum;
  logic [PEAK_W-1:0]   peak_new;

  always_comb begin
    if (sample_width_r == WIDTH_16BIT) begin
      wide_sample = in_raw_sample;
    end else begin
      wide_sample = {in_raw_sample[7] ^ 1'b1, in_raw_sample[6:0], 8'h00};
    end
    abs_sample = wide_sample[SAMPLE_W-1] ? (~wide_sample + SAMPLE_W'(1)) : wide_sample;
    step_eff   = (step_size_r < STEP_W'(MIN_STEP)) ? STEP_W'(MIN_STEP) : step_size_r;
    phase_sum  = phase_r + PHASE_W'(step_eff);
    peak_new   = (mag_r > peak_r) ? mag_r : peak_r;
    sts.skip   = (phase_r >= ONE_POS);
    sts.last   = (phase_sum >= ONE_POS);
  end

  always_comb begin
    phase_nxt = phase_r;
    peak_nxt  = peak_r;
    if (cmd.load && sts.skip) begin
      phase_nxt = in_end_of_sound ? '0 : phase_r - ONE_POS;
      peak_nxt  = in_end_of_sound ? '0 : peak_r;
    end else if (cmd.emit) begin
      if (sts.last) begin
        phase_nxt = eos_r ? '0 : phase_sum - ONE_POS;
        peak_nxt  = eos_r ? '0 : peak_new;
      end else begin
        phase_nxt = phase_sum;
        peak_nxt  = peak_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r    <= STEP_RESET;
      sample_width_r <= WIDTH_RESET;
      phase_r        <= '0;
      peak_r         <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_STEP_SIZE) begin
        step_size_r <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_SAMPLE_WIDTH) begin
        sample_width_r <= cfg_data[WIDTH_W-1:0];
      end
      phase_r <= phase_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= wide_sample;
      mag_r    <= abs_sample[SAMPLE_W-1:SAMPLE_W-PEAK_W];
      eos_r    <= in_end_of_sound;
    end
    if (cmd.emit) begin
      out_sample_r    <= sample_r;
      out_peak_r      <= peak_new;
      out_run_last_r  <= sts.last;
      out_sound_end_r <= sts.last & eos_r;
    end
  end

  assign out_sample     = out_sample_r;
  assign out_peak_level = out_peak_r;
  assign out_run_last   = out_run_last_r;
  assign out_sound_end  = out_sound_end_r;

endmodule

[rtl/nsrc_ctrl.sv]
// nsrc_ctrl: sequencer for accept and per-output emit, owns the result valid flag
// depends on nsrc_pkg; commands nsrc_datapath
module nsrc_ctrl
  import nsrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output ctrl_cmd_t  cmd,
  input  dp_status_t sts
);

  ctrl_state_t st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    slot_free = !out_valid_r || !out_stall;
    in_stall  = 1'b1;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && !sts.skip) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = slot_free;
        if (slot_free && sts.last) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_EMIT))
    else $error("result valid raised outside emit state");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && out_valid_r && out_stall) |=> (st_r == ST_EMIT && out_valid_r))
    else $error("emit progressed while result slot was blocked");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last) |=> !in_stall)
    else $error("input still stalled after final output of a transaction");
`endif

endmodule

[sim/nsrc_checker.sv]
// nsrc_checker: watches the cfg, in and out channels of the nearest sample rate converter,
// predicts every output sample and compares each accepted result field by field
// depends on nsrc_pkg
module nsrc_checker
  import nsrc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [STEP_W-1:0]          cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [SAMPLE_W-1:0]        in_raw_sample,
  input  logic                       in_end_of_sound,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic [PEAK_W-1:0]          out_peak_level,
  input  logic                       out_run_last,
  input  logic                       out_sound_end,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);

  localparam int ONE_POS  = 1 << FRAC_BITS_DEF;
  localparam int MIN_STEP = (ONE_POS + MAX_OUT - 1) / MAX_OUT;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [PEAK_W-1:0]   peak;
    logic                run_last;
    logic                sound_end;
  } out_sample_t;

  out_sample_t        expected_samples[$];
  out_sample_t        head;
  logic [STEP_W-1:0]  step_reg  = STEP_RESET;
  logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
  int                 phase_acc = 0;
  int                 peak_hold = 0;
  int                 errs      = 0;
  int                 n_checked = 0;

  // repeats or skips one input sample according to the phase accumulator
  function automatic void resample(input logic [SAMPLE_W-1:0] raw, input logic eos);
    int          s;
    int          mag;
    int          step_eff;
    int          n;
    out_sample_t cur;
    out_sample_t prev;
    if (width_reg == WIDTH_16BIT) s = int'($signed(raw));
    else s = (int'(raw[7:0]) - 128) * 256;
    mag      = (s < 0 ? -s : s) >> 8;
    step_eff = (int'(step_reg) < MIN_STEP) ? MIN_STEP : int'(step_reg);
    n        = 0;
    prev     = '0;
    while (phase_acc < ONE_POS && n < MAX_OUT) begin
      if (mag > peak_hold) peak_hold = mag;
      phase_acc = phase_acc + step_eff;
      cur.sample    = SAMPLE_W'(s);
      cur.peak      = PEAK_W'(peak_hold);
      cur.run_last  = 1'b0;
      cur.sound_end = 1'b0;
      if (n > 0) expected_samples.push_back(prev);
      prev = cur;
      n++;
    end
    if (n > 0) begin
      prev.run_last  = 1'b1;
      prev.sound_end = eos;
      expected_samples.push_back(prev);
    end
    phase_acc = (phase_acc >= ONE_POS) ? phase_acc - ONE_POS : 0;
    if (eos) begin
      phase_acc = 0;
      peak_hold = 0;
    end
  endfunction

  task automatic check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      if (errs < 40)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_reg  = STEP_RESET;
      width_reg = WIDTH_RESET;
      phase_acc = 0;
      peak_hold = 0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEP_SIZE) step_reg = cfg_data;
        else if (cfg_index == REG_SAMPLE_WIDTH) width_reg = cfg_data[WIDTH_W-1:0];
      end
      if (in_valid && !in_stall) resample(in_raw_sample, in_end_of_sound);
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          if (errs < 40)
            $display("%0t: unexpected output transaction: expected none, got sample %0d",
                     $time, out_sample);
          errs++;
        end else begin
          head = expected_samples.pop_front();
          check_field("out_sample", int'($signed(head.sample)), int'(out_sample));
          check_field("out_peak_level", int'(head.peak), int'(out_peak_level));
          check_field("out_run_last", int'(head.run_last), int'(out_run_last));
          check_field("out_sound_end", int'(head.sound_end), int'(out_sound_end));
          n_checked++;
        end
      end
    end
    fail_count <= errs;
    pending    <= expected_samples.size();
    checked    <= n_checked;
  end

endmodule

[sim/tb.sv]
// tb: stimulus and verdict for the nearest sample rate converter
// drives directed and random samples under several register settings with random gaps
// depends on nsrc_pkg, nearest_sample_rate_converter and nsrc_checker
module tb
  import nsrc_pkg::*;
();

  localparam int ITEMS       = 430;
  localparam int QUIET_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [6] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0080, 16'h00FF
  };

  logic                       clk;
  logic                       rst_n           = 1'b0;
  logic                       cfg_valid       = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index       = REG_STEP_SIZE;
  logic [STEP_W-1:0]          cfg_data        = '0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  logic [SAMPLE_W-1:0]        in_raw_sample   = '0;
  logic                       in_end_of_sound = 1'b0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [PEAK_W-1:0]          out_peak_level;
  logic                       out_run_last;
  logic                       out_sound_end;
  int                         fail_count;
  int                         pending;
  int                         checked;
  int                         in_count        = 0;
  int                         cfg_count       = 0;
  int                         quiet_cycles    = 0;

  nearest_sample_rate_converter uut (.*);
  nsrc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) in_count <= in_count + 1;
    if (cfg_valid && cfg_ready) cfg_count <= cfg_count + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: one long hold-off early in the random part, then random stall patterns
  initial begin : out_stall_gen
    int mode;
    int len;
    bit held;
    held = 1'b0;
    forever begin
      if (!held && in_count >= 30) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (250) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        len  = (mode == 9) ? $urandom_range(10, 40) : $urandom_range(1, 30);
        repeat (len) begin
          if (mode < 3) out_stall <= 1'b0;
          else if (mode < 9) out_stall <= ($urandom_range(0, 3) == 0);
          else out_stall <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= STEP_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input int step_val, input int width_val);
    write_reg(REG_STEP_SIZE, step_val);
    write_reg(REG_SAMPLE_WIDTH, width_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic eos);
    int r;
    int gap;
    in_valid        <= 1'b1;
    in_raw_sample   <= raw;
    in_end_of_sound <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = $urandom_range(0, 19);
    if (r < 12) gap = 0;
    else if (r < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every predicted output has arrived and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int                  step_val;
    int                  width_val;
    int                  count;
    int                  r;
    bit                  first;
    logic [SAMPLE_W-1:0] raw;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting: one output per sample, 16-bit extremes
    send_sample(16'h0000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8001, 1'b1);
    drain();

    // step below the minimum, 8-bit mode
    apply_setting(0, 1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h12FF, 1'b1);
    drain();

    // largest step, unused width code: skipped samples, end of sound on a skipped one
    apply_setting(8191, 3);
    send_sample(16'h0080, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h1234, 1'b1);
    send_sample(16'h00AA, 1'b0);
    drain();

    // 2x upsampling, width code zero
    apply_setting(128, 0);
    send_sample(16'h5501, 1'b0);
    send_sample(16'hAA7F, 1'b1);
    drain();

    // unused register index, then step 4096 in 16-bit mode
    write_reg(REG_SPARE, 8191);
    apply_setting(4096, 2);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    drain();

    apply_setting(1, 2);
    send_sample(16'h7FFF, 1'b1);
    drain();

    apply_setting(16, 2);
    send_sample(16'h1111, 1'b0);
    drain();

    first = 1'b1;
    while (in_count < ITEMS) begin
      if (first) begin
        step_val  = 128;
        width_val = 2;
        count     = 80;
      end else begin
        r = $urandom_range(0, 9);
        case (r)
          0: step_val = $urandom_range(0, 15);
          1: step_val = $urandom_range(4097, 8191);
          2: step_val = 4096;
          3: step_val = 16;
          default: step_val = $urandom_range(17, 600);
        endcase
        width_val = $urandom_range(0, 5);
        if (width_val > 3) width_val = 2;
        count = $urandom_range(20, 60);
      end
      first = 1'b0;
      apply_setting(step_val, width_val);
      repeat (count) begin
        r = $urandom_range(0, 7);
        if (r == 0) raw = CORNER_SAMPLES[3'($urandom_range(0, 5))];
        else raw = SAMPLE_W'($urandom());
        send_sample(raw, $urandom_range(0, 9) == 0);
      end
      drain();
    end

    repeat (16) @(posedge clk);
    $display("run covered %0d input samples, %0d output samples checked, %0d register writes",
             in_count, checked, cfg_count);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
